/* hdl/gaussian_blur_3x3_stream_top_defines.svh */
// Assertion macros shared by the blur block.
`ifndef GAUSSIAN_BLUR_3X3_STREAM_TOP_DEFINES_SVH
`define GAUSSIAN_BLUR_3X3_STREAM_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define GB3_ASSERT_IMPLIES(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gb3 check failed");

// Next-cycle implication, checked out of reset.
`define GB3_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gb3 check failed");

`endif

/* hdl/gb3_pkg.sv */
// Types and constants of the 3x3 binomial blur block.
`timescale 1ns / 1ps
package gb3_pkg;

	localparam int CH_BITS    = 16;
	localparam int NUM_CH     = 4;
	localparam int MAX_WIDTH  = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int MAX_HEIGHT = 4096;
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int FW_W       = 11;
	localparam int FH_W       = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = FIFO_PTR_W + 1;
	// row sum a + 2b + c and the full 16x sum
	localparam int ROWSUM_W   = CH_BITS + 2;
	localparam int TOTAL_W    = CH_BITS + 4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

	localparam logic [FW_W-1:0] FW_RESET = FW_W'(1024);
	localparam logic [FH_W-1:0] FH_RESET = FH_W'(1024);
	localparam logic [FW_W-1:0] FW_MIN   = FW_W'(3);
	localparam logic [FW_W-1:0] FW_MAX   = FW_W'(MAX_WIDTH);
	localparam logic [FH_W-1:0] FH_MIN   = FH_W'(3);
	localparam logic [FH_W-1:0] FH_MAX   = FH_W'(MAX_HEIGHT);

	typedef logic [CH_BITS-1:0] chan_t;
	typedef chan_t [NUM_CH-1:0] pix_t;
	// one lane's 3x3 neighborhood: [row][col]
	typedef chan_t [2:0][2:0] lane_win_t;

	typedef struct packed {
		chan_t pixel_ch0;
		chan_t pixel_ch1;
		chan_t pixel_ch2;
		chan_t pixel_ch3;
	} in_req_t;

	typedef struct packed {
		chan_t blur_ch0;
		chan_t blur_ch1;
		chan_t blur_ch2;
		chan_t blur_ch3;
		logic  row_end;
		logic  frame_end;
	} out_req_t;

	// line store word: previous row and the row before it
	typedef struct packed {
		pix_t mid;
		pix_t top;
	} line_word_t;

endpackage

/* hdl/gaussian_blur_3x3_stream_top.sv */
// Streaming 3x3 binomial blur over a padded four-channel raster image.
`timescale 1ns / 1ps
// Takes one pixel per clock while the output queue has room for every result
// in flight: the line store is a single RAM that is read for the arriving
// pixel and written back in the next cycle, and four channel lanes add the
// window in two register stages. Pixels in the first two rows or columns
// give no result. Writing either register restarts the frame. The line store
// needs no clearing after reset.
`include "gaussian_blur_3x3_stream_top_defines.svh"
module gaussian_blur_3x3_stream_top
	import gb3_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_req_t               in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_req_t              out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// configuration and position counters
	logic [FW_W-1:0]  frame_width_q;
	logic [FH_W-1:0]  frame_height_q;
	logic [FW_W-1:0]  w_eff;
	logic [FH_W-1:0]  h_eff;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic             last_col;
	logic             last_row;
	logic             in_acc;
	logic             cfg_acc;
	logic             cfg_hit;

	// pipeline
	logic             vld_s1, res_s1, re_s1, fe_s1;
	logic [COL_W-1:0] col_s1;
	pix_t             px_s1;
	pix_t             in_px;
	line_word_t       rd_word;
	line_word_t       wr_word;
	pix_t             win_q [3][3];
	logic             vld_s2, re_s2, fe_s2;
	logic             vld_s3, re_s3, fe_s3;
	chan_t            blur [NUM_CH];
	out_req_t         res_word;

	// output queue
	out_req_t              fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;
	logic [FIFO_CNT_W-1:0] inflight;
	logic                  push;
	logic                  pop;

	assign in_px = {in_data.pixel_ch3, in_data.pixel_ch2, in_data.pixel_ch1,
		in_data.pixel_ch0};

	// clamp the frame size to its legal range
	always_comb begin
		w_eff = frame_width_q;
		if (frame_width_q < FW_MIN) begin
			w_eff = FW_MIN;
		end else if (frame_width_q > FW_MAX) begin
			w_eff = FW_MAX;
		end
		h_eff = frame_height_q;
		if (frame_height_q < FH_MIN) begin
			h_eff = FH_MIN;
		end else if (frame_height_q > FH_MAX) begin
			h_eff = FH_MAX;
		end
	end

	assign last_col = (FW_W'(col_q) + FW_W'(1)) >= w_eff;
	assign last_row = (FH_W'(row_q) + FH_W'(1)) >= h_eff;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign in_acc    = in_valid && in_ready;

	// register decode
	always_comb begin
		unique case (cfg_index) inside
			REG_FRAME_WIDTH, REG_FRAME_HEIGHT: cfg_hit = 1'b1;
			default:                           cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FW_RESET;
			frame_height_q <= FH_RESET;
			col_q          <= '0;
			row_q          <= '0;
		end else if (cfg_acc && cfg_hit) begin
			if (cfg_index == REG_FRAME_WIDTH) begin
				frame_width_q <= cfg_data[FW_W-1:0];
			end else begin
				frame_height_q <= cfg_data[FH_W-1:0];
			end
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// stage 1: pixel waits for its line store read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			res_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_acc;
			res_s1 <= in_acc && (col_q >= COL_W'(2)) && (row_q >= ROW_W'(2));
		end
	end

	always_ff @(posedge clk) begin
		col_s1 <= col_q;
		px_s1  <= in_px;
		re_s1  <= last_col;
		fe_s1  <= last_col && last_row;
	end

	// line store: read on accept, shift rows down in the next cycle
	assign wr_word.top = rd_word.mid;
	assign wr_word.mid = px_s1;

	gb3_ram #(
		.WIDTH ($bits(line_word_t)),
		.DEPTH (MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (vld_s1),
		.waddr (col_s1),
		.wdata (wr_word),
		.raddr (col_q),
		.rdata (rd_word)
	);

	// stage 2: window shifts in the new column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (vld_s1) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2] <= rd_word.top;
			win_q[1][2] <= rd_word.mid;
			win_q[2][2] <= px_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1 && res_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		re_s2 <= re_s1;
		fe_s2 <= fe_s1;
		re_s3 <= re_s2;
		fe_s3 <= fe_s2;
	end

	// one lane per channel
	for (genvar k = 0; k < NUM_CH; k++) begin : g_lane
		lane_win_t lwin;

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					lwin[i][j] = win_q[i][j][k];
				end
			end
		end

		gb3_lane u_lane (
			.clk  (clk),
			.win  (lwin),
			.blur (blur[k])
		);
	end

	// merge lanes and flags into one result
	always_comb begin
		res_word.blur_ch0  = blur[0];
		res_word.blur_ch1  = blur[1];
		res_word.blur_ch2  = blur[2];
		res_word.blur_ch3  = blur[3];
		res_word.row_end   = re_s3;
		res_word.frame_end = fe_s3;
	end

	// output queue; input held back when results in flight could overflow it
	assign push     = vld_s3;
	assign pop      = out_valid && out_ready;
	assign out_valid = cnt_q != '0;
	assign out_data  = fifo_q[rd_ptr_q];
	assign inflight = FIFO_CNT_W'(vld_s1 && res_s1) + FIFO_CNT_W'(vld_s2)
		+ FIFO_CNT_W'(vld_s3);
	assign in_ready = (cnt_q + inflight) < FIFO_CNT_W'(FIFO_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= res_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			cnt_q <= cnt_q + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
		end
	end

	// checks
	`GB3_ASSERT_IMPLIES(a_no_overflow, push && !pop, cnt_q < FIFO_CNT_W'(FIFO_DEPTH))
	`GB3_ASSERT_IMPLIES(a_col_in_frame, in_acc, FW_W'(col_q) < w_eff)
	`GB3_ASSERT_IMPLIES(a_ram_no_collide, vld_s1 && in_acc, col_s1 != col_q)
	`GB3_ASSERT_IMPLIES(a_frame_end_row_end, out_valid && out_data.frame_end, out_data.row_end)
	`GB3_ASSERT_NEXT(a_result_flows, vld_s2, vld_s3)

endmodule

/* hdl/gb3_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module gb3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/gb3_lane.sv */
// One channel lane: weighted 3x3 sum with rounding, two adder stages.
`timescale 1ns / 1ps
module gb3_lane
	import gb3_pkg::*;
(
	input  logic      clk,
	input  lane_win_t win,
	output chan_t     blur
);

	logic [ROWSUM_W-1:0] row_sum [3];
	logic [ROWSUM_W-1:0] row_sum_s3 [3];
	logic [TOTAL_W-1:0]  total;

	// horizontal 1-2-1 per row
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			row_sum[i] = ROWSUM_W'(win[i][0]) + {1'b0, win[i][1], 1'b0}
				+ ROWSUM_W'(win[i][2]);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			row_sum_s3[i] <= row_sum[i];
		end
	end

	// vertical 1-2-1, then round to nearest
	assign total = TOTAL_W'(row_sum_s3[0]) + {1'b0, row_sum_s3[1], 1'b0}
		+ TOTAL_W'(row_sum_s3[2]) + TOTAL_W'(8);
	assign blur = total[TOTAL_W-1:4];

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the streaming 3x3 binomial blur block.
`timescale 1ns / 1ps
module testbench;
	import gb3_pkg::*;

	// register indexes past the end of the map; writes there do nothing
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);
	localparam int SETTLE_CYCLES = 8;     // padding pixels give no result
	localparam int TAIL_CYCLES   = 20;
	localparam int STALL_LIMIT   = 4000;  // cycles with no request accepted anywhere
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_PIXELS = 1500;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_req_t               in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_req_t              out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	gaussian_blur_3x3_stream_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 10 ns clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// blur predictor state
	in_req_t         line_mid [MAX_WIDTH] = '{default: '0};
	in_req_t         line_top [MAX_WIDTH] = '{default: '0};
	in_req_t         blur_win [3][3]      = '{default: '0};
	logic [FW_W-1:0] cur_width  = FW_RESET;
	logic [FH_W-1:0] cur_height = FH_RESET;
	int unsigned     col_cnt    = 0;
	int unsigned     row_cnt    = 0;
	out_req_t        pending_blur [$];

	// run bookkeeping
	int unsigned errors        = 0;
	int unsigned pixels_sent   = 0;
	int unsigned blurs_checked = 0;
	int unsigned frames_closed = 0;
	int unsigned reg_writes    = 0;
	int unsigned tx_gap_max    = 0;
	int unsigned rx_gap_max    = 0;
	int unsigned rx_hold_req   = 0;

	function automatic int unsigned clamp_dim(int unsigned v, int unsigned lo, int unsigned hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic chan_t lane_of(in_req_t p, int k);
		case (k)
			0: return p.pixel_ch0;
			1: return p.pixel_ch1;
			2: return p.pixel_ch2;
			default: return p.pixel_ch3;
		endcase
	endfunction

	// 16x weighted window sum for one channel, rounded, ties up
	function automatic chan_t blur_lane(int k);
		int unsigned s;
		s = 4 * lane_of(blur_win[1][1], k)
			+ 2 * (lane_of(blur_win[0][1], k) + lane_of(blur_win[2][1], k)
				+ lane_of(blur_win[1][0], k) + lane_of(blur_win[1][2], k))
			+ lane_of(blur_win[0][0], k) + lane_of(blur_win[0][2], k)
			+ lane_of(blur_win[2][0], k) + lane_of(blur_win[2][2], k);
		return chan_t'((s + 8) >> 4);
	endfunction

	// advance the predictor by one accepted pixel
	task automatic predict_blur(in_req_t px);
		int unsigned ew, eh, c, r;
		in_req_t     top, mid;
		out_req_t    res;
		ew = clamp_dim(32'(cur_width), 32'(FW_MIN), 32'(FW_MAX));
		eh = clamp_dim(32'(cur_height), 32'(FH_MIN), 32'(FH_MAX));
		c  = col_cnt;
		r  = row_cnt;
		top = line_top[c];
		mid = line_mid[c];
		line_top[c] = mid;
		line_mid[c] = px;
		for (int i = 0; i < 3; i++) begin
			blur_win[i][0] = blur_win[i][1];
			blur_win[i][1] = blur_win[i][2];
		end
		blur_win[0][2] = top;
		blur_win[1][2] = mid;
		blur_win[2][2] = px;
		// interior pixel one row up, one column left
		if (c >= 2 && r >= 2) begin
			res.blur_ch0  = blur_lane(0);
			res.blur_ch1  = blur_lane(1);
			res.blur_ch2  = blur_lane(2);
			res.blur_ch3  = blur_lane(3);
			res.row_end   = (c + 1 >= ew);
			res.frame_end = (c + 1 >= ew) && (r + 1 >= eh);
			pending_blur.push_back(res);
		end
		if (c + 1 >= ew) begin
			col_cnt = 0;
			row_cnt = (r + 1 >= eh) ? 0 : r + 1;
		end else begin
			col_cnt = c + 1;
		end
	endtask

	function automatic chan_t rand_chan();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return chan_t'($urandom);
		endcase
	endfunction

	function automatic in_req_t rand_pixel();
		in_req_t p;
		p.pixel_ch0 = rand_chan();
		p.pixel_ch1 = rand_chan();
		p.pixel_ch2 = rand_chan();
		p.pixel_ch3 = rand_chan();
		return p;
	endfunction

	function automatic int unsigned pick_gap();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 3;
			default: return 16;
		endcase
	endfunction

	// send one pixel request; entered and left at a falling edge
	task automatic push_pixel(in_req_t px);
		int unsigned gap;
		gap = $urandom_range(0, tx_gap_max);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data  = px;
		do @(posedge clk); while (!in_ready);
		predict_blur(px);
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic send_pixels(int unsigned n);
		repeat (n) push_pixel(rand_pixel());
	endtask

	// stop the stream and let the block go idle
	task automatic drain();
		in_valid = 1'b0;
		while (pending_blur.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		drain();
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		// any mapped write restarts the frame
		if (idx == REG_FRAME_WIDTH) begin
			cur_width = data[FW_W-1:0];
			col_cnt = 0;
			row_cnt = 0;
		end else if (idx == REG_FRAME_HEIGHT) begin
			cur_height = data[FH_W-1:0];
			col_cnt = 0;
			row_cnt = 0;
		end
		reg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_frame(int unsigned w, int unsigned h);
		write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
		write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
	endtask

	// reset width: part of the first padding row, so no result may appear
	task automatic test_reset_defaults();
		tx_gap_max = 0;
		rx_gap_max = 1;
		send_pixels(64);
	endtask

	// saturated, mixed and rounding frames at the smallest size
	task automatic test_field_extremes();
		in_req_t p;
		tx_gap_max = 3;
		rx_gap_max = 3;
		set_frame(3, 3);
		repeat (9) push_pixel('1);
		for (int k = 0; k < 9; k++) begin
			p.pixel_ch0 = k[0] ? '1 : '0;
			p.pixel_ch1 = k[0] ? '0 : '1;
			p.pixel_ch2 = chan_t'(16'h8000);
			p.pixel_ch3 = chan_t'(16'h0001) << k;
			push_pixel(p);
		end
		// lone center pixel: sums of 4, 8 (a tie), 12 and 28
		for (int k = 0; k < 9; k++) begin
			p = '0;
			if (k == 4) begin
				p.pixel_ch0 = chan_t'(1);
				p.pixel_ch1 = chan_t'(2);
				p.pixel_ch2 = chan_t'(3);
				p.pixel_ch3 = chan_t'(7);
			end
			push_pixel(p);
		end
	endtask

	// register values past both ends of their ranges
	task automatic test_size_extremes();
		tx_gap_max = 1;
		rx_gap_max = 1;
		write_reg(REG_FRAME_WIDTH, '0);
		write_reg(REG_FRAME_HEIGHT, '1);
		send_pixels(3 * 6);
		write_reg(REG_FRAME_WIDTH, '1);
		write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(1));
		send_pixels(64);
		write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(2));
		write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(2));
		send_pixels(18);
	endtask

	// a write in mid frame starts a new frame
	task automatic test_restart_mid_frame();
		tx_gap_max = 4;
		rx_gap_max = 4;
		set_frame(6, 5);
		send_pixels(14);
		write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(5));
		send_pixels(30);
	endtask

	// writes past the register map leave the frame running
	task automatic test_unmapped_index();
		tx_gap_max = 2;
		rx_gap_max = 2;
		set_frame(7, 5);
		send_pixels(17);
		write_reg(REG_SPARE_2, CFG_DATA_W'($urandom));
		write_reg(REG_SPARE_3, CFG_DATA_W'($urandom));
		send_pixels(18);
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_output_backpressure();
		tx_gap_max = 0;
		rx_gap_max = 2;
		set_frame(12, 8);
		rx_hold_req = HOLD_CYCLES;
		send_pixels(96);
	endtask

	// sender waits in mid frame until every result is out
	task automatic test_sender_pause();
		tx_gap_max = 16;
		rx_gap_max = 16;
		set_frame(10, 6);
		send_pixels(30);
		in_valid = 1'b0;
		while (pending_blur.size() != 0) @(negedge clk);
		send_pixels(30);
	endtask

	// random frame sizes, mostly whole frames, some cut short
	task automatic test_random_frames(int unsigned target);
		int unsigned w, h, ew, eh, n, mode, start;
		logic [CFG_DATA_W-1:0] d;
		start = pixels_sent;
		while (pixels_sent - start < target) begin
			tx_gap_max = pick_gap();
			rx_gap_max = pick_gap();
			case ($urandom_range(0, 19))
				0: w = $urandom_range(0, 2);
				1, 2: w = $urandom_range(13, 40);
				default: w = $urandom_range(3, 12);
			endcase
			case ($urandom_range(0, 19))
				0: h = $urandom_range(0, 2);
				1: h = $urandom_range(9, 14);
				default: h = $urandom_range(3, 8);
			endcase
			if (w > 12 && h > 4)
				h = $urandom_range(3, 4);
			mode = $urandom_range(0, 9);
			if (mode == 0)
				write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
					CFG_DATA_W'($urandom));
			// upper data bits are outside the width register
			if (mode != 1 && mode != 3) begin
				d = CFG_DATA_W'(w);
				d[CFG_DATA_W-1:FW_W] = (CFG_DATA_W-FW_W)'($urandom);
				write_reg(REG_FRAME_WIDTH, d);
			end
			if (mode != 1 && mode != 2)
				write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
			ew = clamp_dim(32'(cur_width), 32'(FW_MIN), 32'(FW_MAX));
			eh = clamp_dim(32'(cur_height), 32'(FH_MIN), 32'(FH_MAX));
			n = ew * eh * $urandom_range(1, 2);
			if ($urandom_range(0, 6) == 0)
				n = $urandom_range(1, ew * eh - 1);
			send_pixels(n);
		end
	endtask

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
		end
	endfunction

	// compare each result with the oldest prediction
	initial begin
		out_req_t want;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_blur.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none actual %h", $time, out_data);
				end else begin
					want = pending_blur.pop_front();
					check_field("blur_ch0", 32'(want.blur_ch0), 32'(out_data.blur_ch0));
					check_field("blur_ch1", 32'(want.blur_ch1), 32'(out_data.blur_ch1));
					check_field("blur_ch2", 32'(want.blur_ch2), 32'(out_data.blur_ch2));
					check_field("blur_ch3", 32'(want.blur_ch3), 32'(out_data.blur_ch3));
					check_field("row_end", 32'(want.row_end), 32'(out_data.row_end));
					check_field("frame_end", 32'(want.frame_end), 32'(out_data.frame_end));
					blurs_checked++;
					if (want.frame_end)
						frames_closed++;
				end
			end
		end
	end

	// result receiver: random stalls, plus a long hold-off on request
	initial begin
		int unsigned wait_cycles;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			wait_cycles = $urandom_range(0, rx_gap_max) + rx_hold_req;
			rx_hold_req = 0;
			if (wait_cycles > 0) begin
				out_ready = 1'b0;
				repeat (wait_cycles) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// watchdog on cycles with no accepted request
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
		$display("gaussian_blur_3x3_stream_top test failed");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_field_extremes();
		test_size_extremes();
		test_restart_mid_frame();
		test_unmapped_index();
		test_output_backpressure();
		test_sender_pause();
		test_random_frames(RANDOM_PIXELS);

		in_valid = 1'b0;
		while (pending_blur.size() != 0) @(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Run: %0d pixels in, %0d blurred pixels checked, %0d frames closed,",
			pixels_sent, blurs_checked, frames_closed);
		$display("     %0d register writes incl. out-of-range sizes and unmapped indexes.",
			reg_writes);
		if (errors == 0)
			$display("gaussian_blur_3x3_stream_top test passed");
		else
			$display("gaussian_blur_3x3_stream_top test failed");
		$finish;
	end

endmodule
